// ===== hw/rtl/modular_inverse_macros.svh =====
// assertion macros for the modular inverse block
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("modular_inverse assertion failed");

// next-cycle implication, checked outside reset
`define MI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("modular_inverse assertion failed");

`endif

// ===== hw/rtl/mi_pkg.sv =====
// shared constants and controller/datapath interface types for the modular inverse
`timescale 1ns / 1ps

package mi_pkg;

    // default operand width
    localparam int WIDTH_DEF = 32;

    // modulus after reset, truncated to the operand width where used
    localparam logic [63:0] MOD_RESET = 64'd1000000007;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // take a new value, set up remainder and coefficient pairs
        logic div_start;  // clear divider remainder and product accumulator
        logic div_step;   // one quotient bit and one multiply-accumulate step
        logic update;     // fold quotient into remainder and coefficient pairs
        logic out_load;   // reduce coefficient into the output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic r1_zero;    // euclid loop finished
    } t_dp_stat;

endpackage

// ===== hw/rtl/mi_datapath.sv =====
// datapath: remainder and coefficient pairs, shared shift-subtract divider, output register
`timescale 1ns / 1ps

module mi_datapath #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  logic                 i_clk,
    input  mi_pkg::t_dp_cmd      i_cmd,
    input  logic [WIDTH-1:0]     i_value,
    input  logic [WIDTH-1:0]     i_modulus,
    output mi_pkg::t_dp_stat     o_stat,
    output logic [WIDTH-1:0]     o_inverse
);

    // coefficients stay below the modulus in magnitude; partial products below twice that
    localparam int CW = WIDTH + 3;

    logic [WIDTH-1:0] r_r0, r_r1, r_rem, r_dvd, r_inverse;
    logic [CW-1:0]    r_c0, r_c1, r_acc;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_sub;
    logic             q_bit;
    logic [WIDTH-1:0] n_rem;
    logic [CW-1:0]    n_acc;
    logic [CW-1:0]    mag;
    logic [WIDTH-1:0] n_inverse;

    // one restoring division step with the matching step of quotient times c1
    always_comb begin
        rem_sh  = {r_rem, r_dvd[WIDTH-1]};
        rem_sub = rem_sh - {1'b0, r_r1};
        q_bit   = (rem_sh >= {1'b0, r_r1});
        n_rem   = q_bit ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        n_acc   = {r_acc[CW-2:0], 1'b0} - (q_bit ? r_c1 : {CW{1'b0}});
    end

    // final coefficient moved into 0 .. modulus-1
    always_comb begin
        mag = {CW{1'b0}} - r_c0;
        if (i_modulus == {WIDTH{1'b0}}) begin
            n_inverse = {WIDTH{1'b0}};
        end else if (r_c0[CW-1]) begin
            n_inverse = i_modulus - mag[WIDTH-1:0];
        end else begin
            n_inverse = r_c0[WIDTH-1:0];
        end
    end

    // datapath registers, sequenced by the controller
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0 <= i_value;
            r_r1 <= i_modulus;
            r_c0 <= CW'(1);
            r_c1 <= {CW{1'b0}};
        end
        if (i_cmd.div_start) begin
            r_rem <= {WIDTH{1'b0}};
            r_dvd <= r_r0;
            r_acc <= {CW{1'b0}};
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_acc <= n_acc;
        end
        if (i_cmd.update) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_c0 <= r_c1;
            r_c1 <= r_c0 + r_acc;
        end
        if (i_cmd.out_load) begin
            r_inverse <= n_inverse;
        end
    end

    assign o_stat.r1_zero = (r_r1 == {WIDTH{1'b0}});
    assign o_inverse      = r_inverse;

endmodule

// ===== hw/rtl/mi_ctrl.sv =====
// controller: sequences euclid steps and bit-serial divisions, owns the handshakes
`timescale 1ns / 1ps

module mi_ctrl #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  mi_pkg::t_dp_stat i_stat,
    output mi_pkg::t_dp_cmd  o_cmd
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             out_free;

    assign out_free = !r_valid || i_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.div_start = 1'b1;
                n_cnt           = {CNT_W{1'b0}};
                n_state         = i_stat.r1_zero ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= {CNT_W{1'b0}};
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/modular_inverse.sv =====
// Modular inverse by the extended Euclidean algorithm.
// Input channel i_valid/o_ready carries i_value; output channel o_valid/i_ready
// carries o_inverse, the inverse of i_value modulo the configured modulus in
// 0 .. modulus-1 (for a value not coprime to the modulus, the reduced Bezout
// coefficient; zero for a zero value or a zero modulus).
// The modulus is written over i_cfg_valid/o_cfg_ready with i_modulus; the user
// must write it only while no word is in flight, as the block itself does not
// enforce this. It resets to 1000000007. One word is worked on at a time. Each
// Euclid step runs one check, a pass of the shared shift-subtract divider (which
// also forms quotient times coefficient bit by bit), and one update; a word
// takes at most about 1.44*WIDTH+2 steps. o_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it, and the
// next word may be accepted and computed meanwhile, waiting at the end for
// the register to free up. Synchronous reset drops any word in flight.
`timescale 1ns / 1ps
`include "modular_inverse_macros.svh"

module modular_inverse #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_inverse,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [WIDTH-1:0] i_modulus
);

    logic [WIDTH-1:0] r_modulus;
    mi_pkg::t_dp_cmd  cmd;
    mi_pkg::t_dp_stat stat;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mi_pkg::MOD_RESET[WIDTH-1:0];
        end else if (i_cfg_valid) begin
            r_modulus <= i_modulus;
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer
    mi_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // arithmetic
    mi_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_value   (i_value),
        .i_modulus (r_modulus),
        .o_stat    (stat),
        .o_inverse (o_inverse)
    );

    // result always reduced below a nonzero modulus
    `MI_ASSERT_NOW(a_inv_range, o_valid && (r_modulus != '0), o_inverse < r_modulus)
    // only one word in flight: an accepted word closes the input
    `MI_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready)
    // a new result is loaded only once the input has been taken
    `MI_ASSERT_NEXT(a_load_after_accept, o_ready && !(i_valid && o_ready), !$rose(o_valid))

endmodule
